// ===== hw/rtl/memory_bist_sequencer_assert.svh =====
// assertion macros used by the checker file
`ifndef MEMORY_BIST_SEQUENCER_ASSERT_SVH
`define MEMORY_BIST_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbs_pkg.sv =====
package mbs_pkg;

    localparam int WALK_WORDS_DEFAULT = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_BYTES  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_MODE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUIT_ON_ERROR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTINUOUS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS    = 3'd5;

    localparam logic [1:0] TOGGLE_BIT2 = 2'd1;
    localparam logic [1:0] TOGGLE_BIT3 = 2'd2;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 136;

    // output tdata bit positions
    localparam int TD_ADDR_LSB   = 0;
    localparam int TD_WDATA_LSB  = 32;
    localparam int TD_CERR       = 64;
    localparam int TD_ERRCNT_LSB = 65;
    localparam int TD_PASSCNT_LSB = 97;
    localparam int TD_BUSY       = 129;
    localparam int TD_DONE       = 130;
    localparam int TD_FAILED     = 131;
    localparam int TD_USED_W     = 132;

    localparam logic [17:0] BOUNDARY_ZERO = 18'd0;

    typedef struct packed {
        logic        failed;
        logic        done_res;
        logic        busy_res;
        logic [31:0] pass_count;
        logic [31:0] error_count;
        logic        compare_error;
        logic [31:0] write_data;
        logic [31:0] mem_address;
    } res_data_t;

    typedef struct packed {
        logic [1:0] mem_cmd;
        res_data_t  data;
    } res_t;

endpackage

// ===== hw/rtl/memory_bist_sequencer.sv =====
// channel   dir  tuser             tdata
// s_axis    in   op                abort, read_data
// m_axis    out  mem_cmd           mem_address, write_data, compare_error,
//                                  error_count, pass_count, busy_res, done_res, failed
// cfg       in   -                 cfg_index selects register, cfg_data value
//
// one beat per cycle while s_axis_tready is high: the whole tick is decoded between the state
// registers and the result register, and each s_axis beat's result is registered in the result buffer
// a two-entry result buffer keeps s_axis_tready high while one result waits
// rst_n clears configuration and sequencer state and empties both result entries at once
// a stall on m_axis holds the result; a second waiting result drops s_axis_tready
module memory_bist_sequencer #(
    parameter int WALK_WORDS = mbs_pkg::WALK_WORDS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic                            s_axis_tuser,   // op
    input  logic [mbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // abort, read_data
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [1:0]                      m_axis_tuser,   // mem_cmd
    // mem_address, write_data, compare_error, error_count, pass_count,
    // busy_res, done_res, failed
    output logic [mbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [mbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mbs_pkg::*;

    localparam int WALK_W = $clog2(WALK_WORDS + 1);
    localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(WALK_WORDS);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WALK_W = 3'd1;
    localparam logic [2:0] PH_WALK_R = 3'd2;
    localparam logic [2:0] PH_AIA_W  = 3'd3;
    localparam logic [2:0] PH_HOLD   = 3'd4;
    localparam logic [2:0] PH_AIA_R  = 3'd5;

    localparam logic [31:0] ALIGN_MASK = 32'hffff_fffc;
    localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;

    // configuration
    logic [31:0] base_address_reg;
    logic [31:0] length_bytes_reg;
    logic [1:0]  toggle_mode_reg;
    logic        quit_on_error_reg;
    logic        continuous_reg;
    logic [31:0] hold_ticks_reg;

    // sequencer state
    logic [2:0]        phase_reg, phase_next;
    logic [31:0]       cursor_reg, cursor_next;
    logic [WALK_W-1:0] walk_reg, walk_next;
    logic [31:0]       hold_reg, hold_next;
    logic              pend_reg, pend_next;
    logic [31:0]       expect_reg, expect_next;
    logic [31:0]       errors_reg, errors_next;
    logic [31:0]       passes_reg, passes_next;
    logic              aborted_reg, aborted_next;

    // result buffer
    res_t head_reg, skid_reg;
    logic head_valid_reg, skid_valid_reg;
    res_t res;

    logic        in_fire, out_take;
    logic        op, ab;
    logic [31:0] rd;
    logic [31:0] base_al, len_al;

    logic [2:0]        p0;
    logic [WALK_W-1:0] wk0;
    logic              walk_end;
    logic [31:0]       cw, cr, hv;
    logic              inr_w, inr_r, chk_w, chk_r;
    logic              go_w, go_h, go_r;
    logic [31:0]       walk_addr, walk_bit;
    logic [31:0]       pat_w, pat_r;

    function automatic logic [31:0] pattern_for(input logic [31:0] a, input logic [1:0] mode);
        logic flip;
        flip = ((mode == TOGGLE_BIT2) && a[2]) || ((mode == TOGGLE_BIT3) && a[3]);
        return flip ? ~a : a;
    endfunction

    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign out_take = head_valid_reg & m_axis_tready;

    assign op = s_axis_tuser;
    assign ab = s_axis_tdata[0];
    assign rd = s_axis_tdata[32:1];

    assign base_al = base_address_reg & ALIGN_MASK;
    assign len_al  = length_bytes_reg & ALIGN_MASK;

    // phase and walk position after the start or read check
    assign p0  = op ? PH_WALK_W : ((pend_reg && rd != expect_reg && phase_reg != PH_IDLE
                                    && quit_on_error_reg) ? PH_IDLE : phase_reg);
    assign wk0 = op ? '0 : walk_reg;

    assign walk_end  = (wk0 >= WALK_LAST);
    assign walk_addr = base_al + (32'(wk0) << 2);
    assign walk_bit  = 32'd1 << wk0[$clog2(WALK_WORDS+1)-1:0];

    assign cw    = (p0 == PH_AIA_W) ? cursor_reg : base_al;
    assign cr    = (p0 == PH_AIA_R) ? cursor_reg : base_al;
    assign hv    = (p0 == PH_HOLD) ? hold_reg : hold_ticks_reg;
    assign inr_w = (cw - base_al) < len_al;
    assign inr_r = (cr - base_al) < len_al;
    assign chk_w = (cw[17:0] == BOUNDARY_ZERO);
    assign chk_r = (cr[17:0] == BOUNDARY_ZERO);
    assign pat_w = pattern_for(cw, toggle_mode_reg);
    assign pat_r = pattern_for(cr, toggle_mode_reg);

    // chain of phases that can be passed through without a command
    assign go_w = (p0 == PH_AIA_W) || (p0 == PH_WALK_R && walk_end);
    assign go_h = (p0 == PH_HOLD) || (go_w && !inr_w);
    assign go_r = (p0 == PH_AIA_R) || (go_h && hv == '0);

    always_comb
    begin
        phase_next   = p0;
        cursor_next  = cursor_reg;
        walk_next    = wk0;
        hold_next    = hold_reg;
        pend_next    = pend_reg;
        expect_next  = expect_reg;
        errors_next  = errors_reg;
        passes_next  = passes_reg;
        aborted_next = aborted_reg;
        res          = '0;
        res.mem_cmd  = CMD_NONE;

        // start or check of the previous read
        if (op)
        begin
            errors_next  = '0;
            passes_next  = '0;
            aborted_next = 1'b0;
            pend_next    = 1'b0;
            expect_next  = '0;
            cursor_next  = base_al;
        end
        else if (pend_reg)
        begin
            pend_next = 1'b0;
            if (rd != expect_reg)
            begin
                res.data.compare_error = 1'b1;
                if (errors_reg != ALL_ONES)
                    errors_next = errors_reg + 32'd1;
                if (phase_reg != PH_IDLE && quit_on_error_reg)
                begin
                    if (passes_reg != ALL_ONES)
                        passes_next = passes_reg + 32'd1;
                    res.data.done_res = 1'b1;
                end
            end
        end

        // command of this tick
        priority if (p0 == PH_WALK_W && !walk_end)
        begin
            res.mem_cmd          = CMD_WRITE;
            res.data.mem_address = walk_addr;
            res.data.write_data  = walk_bit;
            walk_next            = wk0 + WALK_W'(1);
        end
        else if (p0 == PH_WALK_W)
        begin
            // walking writes done, first read back of the base word
            phase_next           = PH_WALK_R;
            res.mem_cmd          = CMD_READ;
            res.data.mem_address = base_al;
            expect_next          = 32'd1;
            pend_next            = 1'b1;
            walk_next            = WALK_W'(1);
        end
        else if (p0 == PH_WALK_R && !walk_end)
        begin
            res.mem_cmd          = CMD_READ;
            res.data.mem_address = walk_addr;
            expect_next          = walk_bit;
            pend_next            = 1'b1;
            walk_next            = wk0 + WALK_W'(1);
        end
        else if (go_w && inr_w)
        begin
            phase_next  = PH_AIA_W;
            cursor_next = cw;
            if (chk_w && ab)
            begin
                aborted_next      = 1'b1;
                phase_next        = PH_IDLE;
                res.data.done_res = 1'b1;
            end
            else
            begin
                res.mem_cmd          = CMD_WRITE;
                res.data.mem_address = cw;
                res.data.write_data  = pat_w;
                cursor_next          = cw + 32'd4;
            end
        end
        else if (go_h && hv != '0)
        begin
            phase_next = PH_HOLD;
            hold_next  = hv - 32'd1;
            if (ab)
            begin
                aborted_next      = 1'b1;
                phase_next        = PH_IDLE;
                res.data.done_res = 1'b1;
            end
        end
        else if (go_r && inr_r)
        begin
            phase_next  = PH_AIA_R;
            cursor_next = cr;
            if (chk_r && ab)
            begin
                aborted_next = 1'b1;
                if (passes_reg != ALL_ONES)
                    passes_next = passes_reg + 32'd1;
                phase_next        = PH_IDLE;
                res.data.done_res = 1'b1;
            end
            else
            begin
                res.mem_cmd          = CMD_READ;
                res.data.mem_address = cr;
                expect_next          = pat_r;
                pend_next            = 1'b1;
                cursor_next          = cr + 32'd4;
            end
        end
        else if (go_r)
        begin
            if (passes_reg != ALL_ONES)
                passes_next = passes_reg + 32'd1;
            if (continuous_reg)
            begin
                // next pass, first walking-one write
                phase_next           = PH_WALK_W;
                cursor_next          = base_al;
                res.mem_cmd          = CMD_WRITE;
                res.data.mem_address = base_al;
                res.data.write_data  = 32'd1;
                walk_next            = WALK_W'(1);
            end
            else
            begin
                phase_next        = PH_IDLE;
                res.data.done_res = 1'b1;
            end
        end
        else if (p0 != PH_IDLE)
        begin
            phase_next        = PH_IDLE;
            res.data.done_res = 1'b1;
        end

        res.data.error_count = errors_next;
        res.data.pass_count  = passes_next;
        res.data.busy_res    = (phase_next != PH_IDLE);
        res.data.failed      = res.data.done_res && (errors_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg  <= '0;
            length_bytes_reg  <= '0;
            toggle_mode_reg   <= '0;
            quit_on_error_reg <= 1'b0;
            continuous_reg    <= 1'b0;
            hold_ticks_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:  base_address_reg  <= cfg_data;
                CFG_LENGTH_BYTES:  length_bytes_reg  <= cfg_data;
                CFG_TOGGLE_MODE:   toggle_mode_reg   <= cfg_data[1:0];
                CFG_QUIT_ON_ERROR: quit_on_error_reg <= cfg_data[0];
                CFG_CONTINUOUS:    continuous_reg    <= cfg_data[0];
                CFG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cursor_reg  <= '0;
            walk_reg    <= '0;
            hold_reg    <= '0;
            pend_reg    <= 1'b0;
            expect_reg  <= '0;
            errors_reg  <= '0;
            passes_reg  <= '0;
            aborted_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            cursor_reg  <= cursor_next;
            walk_reg    <= walk_next;
            hold_reg    <= hold_next;
            pend_reg    <= pend_next;
            expect_reg  <= expect_next;
            errors_reg  <= errors_next;
            passes_reg  <= passes_next;
            aborted_reg <= aborted_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (head_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                head_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                head_valid_reg <= 1'b0;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (head_valid_reg && !out_take)
                skid_reg <= res;
            else
                head_reg <= res;
        end
        else if (out_take && skid_valid_reg)
        begin
            head_reg <= skid_reg;
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = head_valid_reg;
    assign m_axis_tuser  = head_reg.mem_cmd;
    assign m_axis_tdata  = {(OUT_TDATA_W - TD_USED_W)'(0), head_reg.data};

endmodule

// ===== hw/rtl/mbs_checker.sv =====
`include "memory_bist_sequencer_assert.svh"

module mbs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [1:0]                      m_axis_tuser,   // mem_cmd
    input logic [mbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // result fields
);
    import mbs_pkg::*;

    logic [31:0] wdata;
    assign wdata = m_axis_tdata[TD_WDATA_LSB +: 32];

    // a waiting result stays put
    `MBS_ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // failed only comes with done
    `MBS_ASSERT_NOW(a_failed_done, m_axis_tvalid && m_axis_tdata[TD_FAILED], m_axis_tdata[TD_DONE], "failed without done")

    // a finished test is no longer busy and issues no command
    `MBS_ASSERT_NOW(a_done_quiet, m_axis_tvalid && m_axis_tdata[TD_DONE], !m_axis_tdata[TD_BUSY] && m_axis_tuser == CMD_NONE, "done while busy or commanding")

    // write data only travels with a write
    `MBS_ASSERT_NOW(a_wdata_zero, m_axis_tvalid && m_axis_tuser != CMD_WRITE, wdata == 32'd0, "write data on a non-write beat")

endmodule

bind memory_bist_sequencer mbs_checker u_mbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
